// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_NOW(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port assertion failed");

`endif

// ----- sv/cae_pkg.sv -----
// ----------------------------------------------------------------------------
// cae_pkg
// types and action codes for the 8-bit alu and register execute core
// ----------------------------------------------------------------------------
package cae_pkg;

	localparam logic [4:0] ACT_LDA   = 5'd0;
	localparam logic [4:0] ACT_LDX   = 5'd1;
	localparam logic [4:0] ACT_LDY   = 5'd2;
	localparam logic [4:0] ACT_ADC   = 5'd3;
	localparam logic [4:0] ACT_AND   = 5'd4;
	localparam logic [4:0] ACT_EOR   = 5'd5;
	localparam logic [4:0] ACT_ASL_A = 5'd6;
	localparam logic [4:0] ACT_ASL_M = 5'd7;
	localparam logic [4:0] ACT_BIT   = 5'd8;
	localparam logic [4:0] ACT_CMP   = 5'd9;
	localparam logic [4:0] ACT_CPX   = 5'd10;
	localparam logic [4:0] ACT_CPY   = 5'd11;
	localparam logic [4:0] ACT_INC   = 5'd12;
	localparam logic [4:0] ACT_DEC   = 5'd13;
	localparam logic [4:0] ACT_INX   = 5'd14;
	localparam logic [4:0] ACT_INY   = 5'd15;
	localparam logic [4:0] ACT_DEX   = 5'd16;
	localparam logic [4:0] ACT_DEY   = 5'd17;
	localparam logic [4:0] ACT_CLC   = 5'd18;
	localparam logic [4:0] ACT_CLD   = 5'd19;
	localparam logic [4:0] ACT_CLI   = 5'd20;
	localparam logic [4:0] ACT_CLV   = 5'd21;

	typedef struct packed {
		logic [4:0] action;
		logic [7:0] operand_value;
	} in_t;

	typedef struct packed {
		logic [7:0] result_value;
		logic       write_back;
		logic [7:0] reg_a_out;
		logic [7:0] reg_x_out;
		logic [7:0] reg_y_out;
		logic       carry_out;
		logic       zero_out;
		logic       irq_mask_out;
		logic       decimal_out;
		logic       overflow_out;
		logic       negative_out;
	} out_t;

	// architectural registers and flags
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic       c;
		logic       z;
		logic       i;
		logic       d;
		logic       v;
		logic       n;
	} arch_t;

endpackage

// ----- sv/cae_alu.sv -----
// ----------------------------------------------------------------------------
// cae_alu
// single-pass execute logic: next registers, flags and result byte
// ----------------------------------------------------------------------------
module cae_alu (
	input  cae_pkg::in_t   item,
	input  cae_pkg::arch_t cur,
	output cae_pkg::arch_t nxt,
	output logic [7:0]     res,
	output logic           wb
);

	logic [7:0] op;
	logic [8:0] sum9;
	logic [7:0] cmp_reg;
	logic [8:0] diff9;
	logic [7:0] and_val;
	logic       zn_en;

	assign op      = item.operand_value;
	assign sum9    = {1'b0, cur.a} + {1'b0, op} + {8'd0, cur.c};
	assign and_val = cur.a & op;
	assign diff9   = {1'b0, cmp_reg} - {1'b0, op};

	always_comb begin
		case (item.action)
			cae_pkg::ACT_CPX: cmp_reg = cur.x;
			cae_pkg::ACT_CPY: cmp_reg = cur.y;
			default:          cmp_reg = cur.a;
		endcase
	end

	always_comb begin
		nxt   = cur;
		res   = '0;
		wb    = 1'b0;
		zn_en = 1'b0;
		unique case (item.action) inside
			cae_pkg::ACT_LDA: begin
				nxt.a = op; res = op; zn_en = 1'b1;
			end
			cae_pkg::ACT_LDX: begin
				nxt.x = op; res = op; zn_en = 1'b1;
			end
			cae_pkg::ACT_LDY: begin
				nxt.y = op; res = op; zn_en = 1'b1;
			end
			cae_pkg::ACT_ADC: begin
				nxt.a = sum9[7:0];
				nxt.c = sum9[8];
				// same-sign addends, sum sign differs
				nxt.v = (cur.a[7] ^ sum9[7]) & (op[7] ^ sum9[7]);
				res   = sum9[7:0];
				zn_en = 1'b1;
			end
			cae_pkg::ACT_AND: begin
				nxt.a = and_val; res = and_val; zn_en = 1'b1;
			end
			cae_pkg::ACT_EOR: begin
				nxt.a = cur.a ^ op; res = cur.a ^ op; zn_en = 1'b1;
			end
			cae_pkg::ACT_ASL_A: begin
				nxt.c = cur.a[7];
				nxt.a = {cur.a[6:0], 1'b0};
				res   = {cur.a[6:0], 1'b0};
				zn_en = 1'b1;
			end
			cae_pkg::ACT_ASL_M: begin
				nxt.c = op[7];
				res   = {op[6:0], 1'b0};
				wb    = 1'b1;
				zn_en = 1'b1;
			end
			cae_pkg::ACT_BIT: begin
				res   = and_val;
				nxt.n = op[7];
				nxt.v = op[6];
				nxt.z = (and_val == 8'd0);
			end
			cae_pkg::ACT_CMP, cae_pkg::ACT_CPX, cae_pkg::ACT_CPY: begin
				res   = diff9[7:0];
				nxt.c = ~diff9[8];
				zn_en = 1'b1;
			end
			cae_pkg::ACT_INC: begin
				res = op + 8'd1; wb = 1'b1; zn_en = 1'b1;
			end
			cae_pkg::ACT_DEC: begin
				res = op - 8'd1; wb = 1'b1; zn_en = 1'b1;
			end
			cae_pkg::ACT_INX: begin
				nxt.x = cur.x + 8'd1; res = cur.x + 8'd1; zn_en = 1'b1;
			end
			cae_pkg::ACT_INY: begin
				nxt.y = cur.y + 8'd1; res = cur.y + 8'd1; zn_en = 1'b1;
			end
			cae_pkg::ACT_DEX: begin
				nxt.x = cur.x - 8'd1; res = cur.x - 8'd1; zn_en = 1'b1;
			end
			cae_pkg::ACT_DEY: begin
				nxt.y = cur.y - 8'd1; res = cur.y - 8'd1; zn_en = 1'b1;
			end
			cae_pkg::ACT_CLC: nxt.c = 1'b0;
			cae_pkg::ACT_CLD: nxt.d = 1'b0;
			cae_pkg::ACT_CLI: nxt.i = 1'b0;
			cae_pkg::ACT_CLV: nxt.v = 1'b0;
			default: ;
		endcase
		if (zn_en) begin
			nxt.z = (res == 8'd0);
			nxt.n = res[7];
		end
	end

endmodule

// ----- sv/cpu_alu_register_execute_core.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_register_execute_core
// path: a beat passes the input register, then the result register;
//   throughput one beat per cycle while the consumer does not stall, set by the single-pass alu
// reset: arst_n clears both stage valids and a, x, y and all flags at once
// ----------------------------------------------------------------------------
module cpu_alu_register_execute_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cae_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cae_pkg::out_t out_data
);

	// stage 1: captured input beat
	logic           vld_s1;
	cae_pkg::in_t   item_s1;

	// stage 2: result register, holds while the consumer stalls
	logic           vld_s2;
	cae_pkg::out_t  res_s2;

	// architectural registers and flags
	cae_pkg::arch_t arch_q;

	cae_pkg::arch_t arch_nxt;
	cae_pkg::out_t  res_nxt;
	logic [7:0]     alu_res;
	logic           alu_wb;
	logic           adv;

	// stage 1 moves into the result register when that register is free or
	// being drained this cycle
	assign adv      = vld_s1 & (~vld_s2 | out_ready);
	assign in_ready = ~vld_s1 | adv;

	cae_alu u_alu (
		.item (item_s1),
		.cur  (arch_q),
		.nxt  (arch_nxt),
		.res  (alu_res),
		.wb   (alu_wb)
	);

	// result beat carries the byte and the full register view afterwards
	always_comb begin
		res_nxt.result_value = alu_res;
		res_nxt.write_back   = alu_wb;
		res_nxt.reg_a_out    = arch_nxt.a;
		res_nxt.reg_x_out    = arch_nxt.x;
		res_nxt.reg_y_out    = arch_nxt.y;
		res_nxt.carry_out    = arch_nxt.c;
		res_nxt.zero_out     = arch_nxt.z;
		res_nxt.irq_mask_out = arch_nxt.i;
		res_nxt.decimal_out  = arch_nxt.d;
		res_nxt.overflow_out = arch_nxt.v;
		res_nxt.negative_out = arch_nxt.n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// state commits when the beat leaves stage 1, so the next beat sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
		end else if (adv) begin
			arch_q <= arch_nxt;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

endmodule

// ----- sv/cae_checker.sv -----
// ----------------------------------------------------------------------------
// cae_checker
// port-level checks for the execute core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cae_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input cae_pkg::out_t out_data
);

	logic wb_zero_ok;
	logic wb_neg_ok;

	assign wb_zero_ok = (out_data.zero_out == (out_data.result_value == 8'd0));
	assign wb_neg_ok  = (out_data.negative_out == out_data.result_value[7]);

	// stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// input side only backs up behind a stalled result
	`ASSERT_NOW(a_ready_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

	// memory write-back beats set z and n from the stored byte
	`ASSERT_NOW(a_wb_flags, clk, arst_n, out_valid && out_data.write_back, wb_zero_ok && wb_neg_ok)

	// nothing sets the interrupt mask
	`ASSERT_NOW(a_irq_clear, clk, arst_n, out_valid, !out_data.irq_mask_out)

endmodule

bind cpu_alu_register_execute_core cae_checker u_cae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
